// File: rtl/lbp_pkg.sv
// lbp_pkg: types and constants shared by the lsb-first bit packer
// holds request/response payload structs, request kind codes and field widths
// no dependencies
`timescale 1ns / 1ps

package lbp_pkg;

   localparam int MAX_CODE_BITS_DEFAULT = 32;
   localparam int JOB_QUEUE_DEPTH       = 2;

   localparam int CODE_VALUE_W  = 32;
   localparam int CODE_LENGTH_W = 6;
   localparam int BYTE_W        = 8;
   localparam int PEND_W        = 7;
   localparam int PEND_CNT_W    = 3;

   typedef enum logic [1:0] {
      KIND_BITS  = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_ALIGN = 2'd2,
      KIND_CLEAR = 2'd3
   } lbp_kind_type;

   typedef struct packed {
      lbp_kind_type              req_type;
      logic [CODE_VALUE_W-1:0]   code_value;
      logic [CODE_LENGTH_W-1:0]  code_length;
   } lbp_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
   } lbp_rsp_type;

endpackage

// File: rtl/lbp_queue.sv
// lbp_queue: small register fifo that carries byte jobs from front to back
// generic in width and depth, read data is the head entry
// no dependencies
`timescale 1ns / 1ps

module lbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_wr, do_rd;

   always_comb begin
      do_wr = wr_en && !full;
      do_rd = rd_en && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule

// File: rtl/lbp_front.sv
// lbp_front: accepts requests, keeps the pending bits and turns each request
// into a job of completed bytes; uses lbp_pkg
`timescale 1ns / 1ps

module lbp_front #(
   parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS_DEFAULT,
   parameter int JOB_BYTES     = 4,
   parameter int COUNT_W       = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  lbp_pkg::lbp_req_type          req_data,
   output logic                          job_push,
   output logic [COUNT_W-1:0]            job_count,
   output logic [JOB_BYTES-1:0][7:0]     job_bytes
);

   import lbp_pkg::*;

   localparam int EFF_BITS = (MAX_CODE_BITS < CODE_VALUE_W) ? MAX_CODE_BITS : CODE_VALUE_W;
   localparam int ACC_W    = BYTE_W * (JOB_BYTES + 1);
   localparam int TOTAL_W  = CODE_LENGTH_W + 1;

   logic [PEND_W-1:0]     pend_bits_ff,  pend_bits_in;
   logic [PEND_CNT_W-1:0] pend_count_ff, pend_count_in;

   logic               len_ok;
   logic [ACC_W-1:0]   mask_wide;
   logic [ACC_W-1:0]   value_wide;
   logic [ACC_W-1:0]   acc;
   logic [ACC_W-1:0]   rest;
   logic [TOTAL_W-1:0] total;

   always_comb begin
      len_ok     = (req_data.code_length != '0) &&
                   (req_data.code_length <= CODE_LENGTH_W'(EFF_BITS));
      mask_wide  = ~({ACC_W{1'b1}} << req_data.code_length);
      value_wide = ACC_W'(req_data.code_value) & mask_wide;
      acc        = ACC_W'(pend_bits_ff) | (value_wide << pend_count_ff);
      total      = TOTAL_W'(pend_count_ff) + TOTAL_W'(req_data.code_length);
      // drop the whole bytes, what is left are the new pending bits
      rest       = acc >> (total & ~TOTAL_W'(7));
   end

   always_comb begin
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      job_count     = '0;
      for (int j = 0; j < JOB_BYTES; j++) begin
         job_bytes[j] = acc[j*BYTE_W +: BYTE_W];
      end
      if (accept) begin
         unique case (req_data.req_type)
            KIND_BITS: begin
               if (len_ok) begin
                  job_count     = COUNT_W'(total >> 3);
                  pend_count_in = total[PEND_CNT_W-1:0];
                  pend_bits_in  = rest[PEND_W-1:0];
               end
            end
            KIND_BYTE: begin
               pend_bits_in  = '0;
               pend_count_in = '0;
               if (pend_count_ff != '0) begin
                  job_bytes[0] = {1'b0, pend_bits_ff};
                  job_bytes[1] = req_data.code_value[BYTE_W-1:0];
                  job_count    = COUNT_W'(2);
               end else begin
                  job_bytes[0] = req_data.code_value[BYTE_W-1:0];
                  job_count    = COUNT_W'(1);
               end
            end
            KIND_ALIGN: begin
               pend_bits_in  = '0;
               pend_count_in = '0;
               job_bytes[0]  = {1'b0, pend_bits_ff};
               job_count     = (pend_count_ff != '0) ? COUNT_W'(1) : '0;
            end
            KIND_CLEAR: begin
               pend_bits_in  = '0;
               pend_count_in = '0;
            end
         endcase
      end
      job_push = (job_count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
      end
   end

endmodule

// File: rtl/lbp_back.sv
// lbp_back: takes byte jobs from the queue and hands them out one byte per
// cycle while pop keeps the output register free, through an output register; uses lbp_pkg
`timescale 1ns / 1ps

module lbp_back #(
   parameter int JOB_BYTES = 4,
   parameter int COUNT_W   = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  logic [COUNT_W-1:0]        job_count,
   input  logic [JOB_BYTES-1:0][7:0] job_bytes,
   output logic                      q_pop,
   output logic                      empty,
   input  logic                      pop,
   output lbp_pkg::lbp_rsp_type      rsp_data
);

   import lbp_pkg::*;

   localparam int IDX_W = $clog2(JOB_BYTES);

   logic                      job_valid_ff, job_valid_in;
   logic [COUNT_W-1:0]        job_count_ff, job_count_nx_in;
   logic [JOB_BYTES-1:0][7:0] job_bytes_ff, job_bytes_in;
   logic [IDX_W-1:0]          idx_ff,       idx_in;
   logic                      out_valid_ff, out_valid_in;
   lbp_rsp_type               out_ff,       out_in;

   logic out_adv, emit, cur_last, job_free;

   always_comb begin
      out_adv  = !out_valid_ff || pop;
      emit     = out_adv && job_valid_ff;
      cur_last = (COUNT_W'(idx_ff) == job_count_ff - COUNT_W'(1));
      job_free = !job_valid_ff || (emit && cur_last);
      q_pop    = job_free && !q_empty;

      job_valid_in    = job_valid_ff;
      job_count_nx_in = job_count_ff;
      job_bytes_in    = job_bytes_ff;
      idx_in          = idx_ff;
      out_valid_in    = out_valid_ff;
      out_in          = out_ff;

      if (emit) begin
         out_valid_in       = 1'b1;
         out_in.out_byte    = job_bytes_ff[idx_ff];
         out_in.last_of_run = cur_last;
         idx_in             = idx_ff + IDX_W'(1);
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      // next job goes in as soon as the current one hands out its last byte
      if (q_pop) begin
         job_valid_in    = 1'b1;
         job_count_nx_in = job_count;
         job_bytes_in    = job_bytes;
         idx_in          = '0;
      end else if (job_free) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_count_ff <= job_count_nx_in;
      job_bytes_ff <= job_bytes_in;
      out_ff       <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

// File: rtl/lsb_first_bit_packer.sv
// lsb_first_bit_packer: packs codes lsb first into a byte stream
// path: a request's first byte goes through the job queue, the back end's job register and the output register
// throughput: one request per cycle while the job queue has room; the response side moves
// one byte per cycle while pop keeps up, so a request completing n bytes (0 to 4) holds the back end for n bytes
// reset: synchronous, clears the pending bits, the job queue and the output register
`timescale 1ns / 1ps

module lsb_first_bit_packer #(
   parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = lbp_pkg::JOB_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  lbp_pkg::lbp_req_type req_data,
   output logic                 empty,
   input  logic                 pop,
   output lbp_pkg::lbp_rsp_type rsp_data
);

   import lbp_pkg::*;

   localparam int EFF_BITS  = (MAX_CODE_BITS < CODE_VALUE_W) ? MAX_CODE_BITS : CODE_VALUE_W;
   localparam int BIT_BYTES = (PEND_W + EFF_BITS) / BYTE_W;
   localparam int JOB_BYTES = (BIT_BYTES > 2) ? BIT_BYTES : 2;
   localparam int COUNT_W   = $clog2(JOB_BYTES + 1);
   localparam int JOB_W     = COUNT_W + BYTE_W * JOB_BYTES;
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   logic                      accept;
   logic                      f_push;
   logic [COUNT_W-1:0]        f_count;
   logic [JOB_BYTES-1:0][7:0] f_bytes;
   logic [JOB_W-1:0]          q_rd_data;
   logic                      q_pop, q_full, q_empty;
   logic [QCNT_W-1:0]         q_count;
   logic [COUNT_W-1:0]        b_count;
   logic [JOB_BYTES-1:0][7:0] b_bytes;

   assign accept = push && !q_full;
   assign full   = q_full;

   lbp_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .JOB_BYTES     (JOB_BYTES),
      .COUNT_W       (COUNT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .job_push  (f_push),
      .job_count (f_count),
      .job_bytes (f_bytes)
   );

   lbp_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (f_push),
      .wr_data ({f_count, f_bytes}),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty),
      .count   (q_count)
   );

   assign b_count = q_rd_data[JOB_W-1 -: COUNT_W];
   assign b_bytes = q_rd_data[BYTE_W*JOB_BYTES-1:0];

   lbp_back #(
      .JOB_BYTES (JOB_BYTES),
      .COUNT_W   (COUNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .job_count (b_count),
      .job_bytes (b_bytes),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   // a write-byte request always leaves a job behind
   a_byte_makes_job: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == KIND_BYTE) |=> (q_count != '0))
      else $error("write-byte request produced no job");

   // a zero-length write-bits request never grows the job queue
   a_zero_len_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == KIND_BITS && req_data.code_length == '0)
      |=> (q_count <= $past(q_count)))
      else $error("zero-length request produced a job");

   // reset leaves both the queue and the response register empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && q_empty))
      else $error("block not idle after reset");

endmodule
